### sv/fpa_pkg.sv
package fpa_pkg;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_CMP      = 4'd4,
    OP_MAX      = 4'd5,
    OP_MIN      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT   = 4'd10
  } op_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic        is_mul;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic        lt;
    logic        gt;
    logic        eq;
  } q_entry_t;

  // per-stage side data in the execution pipeline
  typedef struct packed {
    logic        is_mul;
    logic        is_div;
    logic        neg;
    logic        dz;
    logic [31:0] res;
    logic        lt;
    logic        gt;
    logic        eq;
  } meta_t;

endpackage

### sv/fixed_point_alu_q24_8_unit.sv
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | tuser: req_type; tdata: operand_a, operand_b
// out     | out | out_tvalid / out_tready| tdata: result_value; tuser: flags
//
// One request per cycle sustained while out accepts results; the pipeline is built
// around the 32 + FRAC_BITS stage restoring divider.
// Synchronous active-low reset empties the queue and the pipeline.
// A stall on out halts the whole execution pipeline; the 4-entry queue keeps
// in flowing until it fills.
module fixed_point_alu_q24_8_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  in_tuser,   // [3:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [3:0]  out_tuser   // [0] is_less, [1] is_greater, [2] is_equal, [3] divide_by_zero
);
  import fpa_pkg::*;

  q_entry_t ent, qd;
  logic     qv, qpop;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .op_code (in_tuser),
    .a       (in_tdata[31:0]),
    .b       (in_tdata[63:32]),
    .entry   (ent)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (ent),
    .pop_valid  (qv),
    .pop_ready  (qpop),
    .pop_data   (qd)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qv),
    .q_pop     (qpop),
    .q_data    (qd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_tdata),
    .out_flags (out_tuser)
  );

endmodule

### sv/fpa_front.sv
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic [3:0]        op_code,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output fpa_pkg::q_entry_t entry
);
  import fpa_pkg::*;

  logic lt, gt, eq;
  logic [31:0] res;

  assign lt = $signed(a) < $signed(b);
  assign gt = $signed(a) > $signed(b);
  assign eq = (a == b);

  // everything except mul/div resolves here; those finish in the back end
  always_comb begin
    res = 32'd0;
    unique case (op_t'(op_code))
      OP_ADD:      res = a + b;
      OP_SUB:      res = a - b;
      OP_MAX:      res = gt ? a : b;
      OP_MIN:      res = lt ? a : b;
      OP_INC:      res = a + 32'd1;
      OP_DEC:      res = a - 32'd1;
      OP_FROM_INT: res = a << FRAC_BITS;
      OP_TO_INT:   res = $signed(a) >>> FRAC_BITS;
      default:     res = 32'd0;
    endcase
  end

  always_comb begin
    entry.is_mul = (op_t'(op_code) == OP_MUL);
    entry.is_div = (op_t'(op_code) == OP_DIV);
    entry.a      = a;
    entry.b      = b;
    entry.res    = res;
    entry.lt     = lt;
    entry.gt     = gt;
    entry.eq     = eq;
  end

endmodule

### sv/fpa_queue.sv
module fpa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  fpa_pkg::q_entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fpa_pkg::q_entry_t pop_data
);
  import fpa_pkg::*;

  q_entry_t mem_r [QDEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic push, pop;

  assign push_ready = (cnt_r != QCW'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push = push_valid & push_ready;
  assign pop  = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QPW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == QPW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH)) else $error("queue count overflow");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("queue count lost push");

endmodule

### sv/fpa_back.sv
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  fpa_pkg::q_entry_t q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_res,
  output logic [3:0]        out_flags
);
  import fpa_pkg::*;

  localparam int DW = 32 + FRAC_BITS;   // quotient bits of (|a| << F) / |b|

  logic          en;
  logic [DW:0]   v_r;
  meta_t         meta_r [DW+1];
  logic [31:0]   rem_r  [DW+1];
  logic [DW-1:0] qn_r   [DW+1];
  logic [31:0]   d_r    [DW+1];
  logic [63:0]   prod_r;
  logic          out_valid_r;
  logic [31:0]   out_res_r;
  logic [3:0]    out_flags_r;

  logic [31:0] abs_a, abs_b;
  meta_t       m0;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  assign abs_a = q_data.a[31] ? (32'd0 - q_data.a) : q_data.a;
  assign abs_b = q_data.b[31] ? (32'd0 - q_data.b) : q_data.b;

  always_comb begin
    m0.is_mul = q_data.is_mul;
    m0.is_div = q_data.is_div;
    m0.neg    = q_data.a[31] ^ q_data.b[31];
    m0.dz     = q_data.is_div && (q_data.b == 32'd0);
    m0.res    = q_data.res;
    m0.lt     = q_data.lt;
    m0.gt     = q_data.gt;
    m0.eq     = q_data.eq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= m0;
      rem_r[0]  <= 32'd0;
      qn_r[0]   <= {abs_a, {FRAC_BITS{1'b0}}};
      d_r[0]    <= abs_b;
      prod_r    <= 64'($signed(q_data.a) * $signed(q_data.b));
    end
  end

  // product rounding toward zero before the shift
  logic [63:0] prod_adj;
  logic [63:0] prod_sh;
  assign prod_adj = prod_r + (prod_r[63] ? {{(64-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : 64'd0);
  assign prod_sh  = $signed(prod_adj) >>> FRAC_BITS;

  // one restoring divide step per stage
  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [32:0] t, diff;
    logic        ge;
    meta_t       m;
    assign t    = {rem_r[k-1], qn_r[k-1][DW-1]};
    assign diff = t - {1'b0, d_r[k-1]};
    assign ge   = !diff[32];
    always_comb begin
      m = meta_r[k-1];
      if (k == 1 && meta_r[k-1].is_mul) m.res = prod_sh[31:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[k] <= m;
        rem_r[k]  <= ge ? diff[31:0] : t[31:0];
        qn_r[k]   <= {qn_r[k-1][DW-2:0], ge};
        d_r[k]    <= d_r[k-1];
      end
    end
  end

  logic [31:0] q_lo, fin_res;
  meta_t       mf;
  assign mf   = meta_r[DW];
  assign q_lo = qn_r[DW][31:0];
  always_comb begin
    fin_res = mf.res;
    if (mf.is_div) fin_res = mf.dz ? 32'd0 : (mf.neg ? (32'd0 - q_lo) : q_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[DW-1:0], q_pop};
      out_valid_r <= v_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r   <= fin_res;
      out_flags_r <= {mf.dz, mf.eq, mf.gt, mf.lt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_flags = out_flags_r;

  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop) else $error("pop during output stall");
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r)) else $error("pipeline moved while stalled");

endmodule

### test/alu_checker.sv
module alu_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [3:0]  out_tuser,
  output int          fail_count,
  output int          pending
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  flags;  // lt, gt, eq, dz from bit 0
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t compute_alu(logic [3:0] op, logic [31:0] ua, logic [31:0] ub);
    alu_result_t r;
    logic signed [63:0] a, b, p, q;
    logic dz;
    a = {{32{ua[31]}}, ua};
    b = {{32{ub[31]}}, ub};
    dz = 1'b0;
    r.value = '0;
    case (op)
      OP_ADD: r.value = ua + ub;
      OP_SUB: r.value = ua - ub;
      OP_MUL: begin
        p = a * b;
        q = p / (64'sd1 <<< FRAC_BITS);  // truncate toward zero
        r.value = q[31:0];
      end
      OP_DIV: begin
        if (b == 0) dz = 1'b1;
        else begin
          q = (a * (64'sd1 <<< FRAC_BITS)) / b;
          r.value = q[31:0];
        end
      end
      OP_CMP: r.value = '0;
      OP_MAX: r.value = (a > b) ? ua : ub;
      OP_MIN: r.value = (a < b) ? ua : ub;
      OP_INC: r.value = ua + 32'd1;
      OP_DEC: r.value = ua - 32'd1;
      OP_FROM_INT: r.value = ua << FRAC_BITS;
      OP_TO_INT: r.value = $signed(ua) >>> FRAC_BITS;
      default: r.value = '0;
    endcase
    r.flags = {dz, a == b, a > b, a < b};
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alu_result_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(compute_alu(in_tuser, in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h flags=%b", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.value !== out_tdata || e.flags !== out_tuser) begin
            $display("%0t: mismatch expected value=%h flags=%b actual value=%h flags=%b",
                     $time, e.value, e.flags, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### test/tb_top.sv
module tb_top;
  import fpa_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = FRAC_BITS + 35;
  localparam int WATCHDOG  = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 84;
  int          idle_cycles = 0;

  always #10 clk = ~clk;

  fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  alu_checker #(.FRAC_BITS(FRAC_BITS)) chk (.*);

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // tvalid stays up between back-to-back transfers; it drops only while idling
  task automatic send_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(1023) - 512;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_operand();
      b = ($urandom_range(9) == 0) ? a : rand_operand();
      send_req(4'($urandom_range(15)), a, b);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_req(OP_ADD, 32'h7fff_ffff, 32'd1);
    send_req(OP_SUB, 32'h8000_0000, 32'd1);
    send_req(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_req(OP_MUL, 32'hffff_ff01, 32'h0000_0080);
    send_req(OP_MUL, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(OP_DIV, 32'h0000_0100, 32'd0);
    send_req(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_req(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_req(OP_DIV, 32'h7fff_ffff, 32'd1);
    send_req(OP_CMP, 32'd5, 32'd5);
    send_req(OP_CMP, 32'h8000_0000, 32'h7fff_ffff);
    send_req(OP_CMP, 32'h7fff_ffff, 32'h8000_0000);
    send_req(OP_MAX, 32'hffff_ffff, 32'd1);
    send_req(OP_MAX, 32'd7, 32'd7);
    send_req(OP_MIN, 32'hffff_ffff, 32'd1);
    send_req(OP_MIN, 32'd3, 32'd3);
    send_req(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(OP_DEC, 32'h8000_0000, 32'd0);
    send_req(OP_FROM_INT, 32'h00ff_ffff, 32'd0);
    send_req(OP_FROM_INT, 32'hffff_ffff, 32'd0);
    send_req(OP_TO_INT, 32'hffff_ff01, 32'd0);
    send_req(OP_TO_INT, 32'h7fff_ffff, 32'd0);
    send_req(4'd11, 32'd1, 32'd0);
    send_req(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    random_phase(270);
    // hold off until the pipeline has emptied
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 16;
    random_phase(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
